// File: src/msm_pkg.sv
// Shared constants, types and GF(2^8) arithmetic for the masked share multiplier.
package msm_pkg;

	// Fixed field geometry: five byte shares per 40-bit field
	localparam int FIELD_W     = 40;
	localparam int FIELD_BYTES = 5;
	localparam int TBL_N       = 6;

	// Parameter defaults
	localparam int SHARE_COUNT_DEF = 5;
	localparam int MASK_DEGREE_DEF = 1;

	// Public evaluation points, padded with zero
	localparam logic [7:0] PTS [0:TBL_N-1] = '{8'h51, 8'hec, 8'h0d, 8'hb1, 8'h01, 8'h00};

	// Inverse Vandermonde table, padded with zero
	localparam logic [7:0] INVV [0:TBL_N-1][0:TBL_N-1] = '{
		'{8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00},
		'{8'h5d, 8'h5c, 8'he0, 8'he1, 8'h00, 8'h00},
		'{8'hbc, 8'hbc, 8'hbd, 8'hbd, 8'h00, 8'h00},
		'{8'hb1, 8'h0d, 8'h51, 8'hec, 8'h01, 8'h00},
		'{8'h51, 8'hec, 8'h0d, 8'hb1, 8'h01, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	// Control from the pipeline sequencer to each lane
	typedef struct packed {
		logic en;     // stage 1 load enable
		logic check;  // fault-detection terms on
	} lane_ctl_t;

	// GF(2^8) multiply, reduction by x^8+x^4+x^3+x+1
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] r;
		x = a;
		r = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				r = r ^ x;
			end
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		end
		return r;
	endfunction

endpackage

// File: src/msm_lane.sv
// One share lane: share product, re-sharing and per-column contributions.
module msm_lane #(
	parameter int SHARE_COUNT = msm_pkg::SHARE_COUNT_DEF,
	parameter int MASK_DEGREE = msm_pkg::MASK_DEGREE_DEF,
	parameter int LANE        = 0
) (
	input  logic                              clk,
	input  msm_pkg::lane_ctl_t                ctl,
	input  logic [7:0]                        f_byte,
	input  logic [7:0]                        g_byte,
	input  logic [7:0]                        r_byte,
	output logic [SHARE_COUNT-1:0][7:0]       col
);

	logic [7:0] p_s1;
	logic [7:0] r_s1;
	logic [7:0] fg_s1;

	// Stage 1: share product and sum, captured on load
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			p_s1  <= msm_pkg::gf_mul(f_byte, g_byte);
			r_s1  <= r_byte;
			fg_s1 <= f_byte ^ g_byte;
		end
	end

	// Per column: lambda * (p + r*alpha_j), plus the check term where enabled
	for (genvar j = 0; j < SHARE_COUNT; j++) begin : g_col
		localparam int ROW = (SHARE_COUNT - j - 1) % msm_pkg::TBL_N;
		logic [7:0] q;
		logic [7:0] chk;

		assign q = p_s1 ^ msm_pkg::gf_mul(r_s1, msm_pkg::PTS[j]);

		if (j < MASK_DEGREE) begin : g_chk
			assign chk = ctl.check ? msm_pkg::gf_mul(msm_pkg::INVV[ROW][LANE], fg_s1) : 8'h00;
		end else begin : g_nochk
			assign chk = 8'h00;
		end

		assign col[j] = msm_pkg::gf_mul(msm_pkg::INVV[0][LANE], q) ^ chk;
	end

endmodule

// File: src/msm_merge.sv
// Merge stage: XOR of lane contributions per column, registered output shares.
module msm_merge #(
	parameter int SHARE_COUNT = msm_pkg::SHARE_COUNT_DEF
) (
	input  logic                                         clk,
	input  logic                                         en,
	input  logic [SHARE_COUNT-1:0][SHARE_COUNT-1:0][7:0] contrib,
	output logic [msm_pkg::FIELD_W-1:0]                  h_s2
);

	logic [SHARE_COUNT-1:0][7:0]     acc;
	logic [msm_pkg::FIELD_W-1:0]     h_next;

	// Column sums across lanes
	always_comb begin
		for (int j = 0; j < SHARE_COUNT; j++) begin
			acc[j] = 8'h00;
			for (int i = 0; i < SHARE_COUNT; i++) begin
				acc[j] = acc[j] ^ contrib[i][j];
			end
		end
	end

	// Pack into the 40-bit field; shares beyond the field are dropped
	for (genvar j = 0; j < msm_pkg::FIELD_BYTES; j++) begin : g_pack
		if (j < SHARE_COUNT) begin : g_live
			assign h_next[8*j +: 8] = acc[j];
		end else begin : g_pad
			assign h_next[8*j +: 8] = 8'h00;
		end
	end

	// Stage 2 register
	always_ff @(posedge clk) begin
		if (en) begin
			h_s2 <= h_next;
		end
	end

endmodule

// File: src/masked_gf256_share_multiply.sv
// Top level of the masked GF(2^8) share multiplier: lanes, merge and handshake.
//
//  channel   signals                                        direction
//  req       req_valid, req_stall, f_/g_shares, random_bytes into block
//  rsp       rsp_valid, rsp_stall, h_shares                 out of block
//  cfg       cfg_valid, cfg_ready, cfg_check_mode           into block
//
// One beat per cycle sustained while rsp_stall is low: stage 1 holds the lane
// products, stage 2 the merged shares in the output register.
// arst_n clears the stage valids and check_mode; data registers are not reset.
// A stalled result holds stage 2; stage 1 still takes a beat while empty, so
// req_stall rises only with both stages full and rsp_stall high.
module masked_gf256_share_multiply #(
	parameter int SHARE_COUNT = msm_pkg::SHARE_COUNT_DEF,
	parameter int MASK_DEGREE = msm_pkg::MASK_DEGREE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [msm_pkg::FIELD_W-1:0] f_shares,
	input  logic [msm_pkg::FIELD_W-1:0] g_shares,
	input  logic [msm_pkg::FIELD_W-1:0] random_bytes,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [msm_pkg::FIELD_W-1:0] h_shares,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_check_mode
);

	logic                                          check_mode_q;
	logic                                          vld_s1;
	logic                                          vld_s2;
	logic                                          en_s1;
	logic                                          en_s2;
	msm_pkg::lane_ctl_t                            ctl;
	logic [SHARE_COUNT-1:0][SHARE_COUNT-1:0][7:0]  contrib;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			check_mode_q <= cfg_check_mode;
		end
	end

	// Pipeline advance
	assign en_s2     = !vld_s2 || !rsp_stall;
	assign en_s1     = !vld_s1 || en_s2;
	assign req_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= req_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	assign ctl.en    = en_s1;
	assign ctl.check = check_mode_q;

	// Share lanes
	for (genvar i = 0; i < SHARE_COUNT; i++) begin : g_lane
		logic [7:0] f_b;
		logic [7:0] g_b;
		logic [7:0] r_b;

		if (i < msm_pkg::FIELD_BYTES) begin : g_in
			assign f_b = f_shares[8*i +: 8];
			assign g_b = g_shares[8*i +: 8];
			assign r_b = random_bytes[8*i +: 8];
		end else begin : g_zero
			assign f_b = 8'h00;
			assign g_b = 8'h00;
			assign r_b = 8'h00;
		end

		msm_lane #(
			.SHARE_COUNT(SHARE_COUNT),
			.MASK_DEGREE(MASK_DEGREE),
			.LANE       (i)
		) u_lane (
			.clk   (clk),
			.ctl   (ctl),
			.f_byte(f_b),
			.g_byte(g_b),
			.r_byte(r_b),
			.col   (contrib[i])
		);
	end

	// Column merge and output register
	msm_merge #(
		.SHARE_COUNT(SHARE_COUNT)
	) u_merge (
		.clk    (clk),
		.en     (en_s2),
		.contrib(contrib),
		.h_s2   (h_shares)
	);

	assign rsp_valid = vld_s2;

`ifndef SYNTHESIS
	// An accepted beat occupies stage 1 on the next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> vld_s1)
		else $error("accepted beat not held in stage 1");

	// A stage 1 beat moves to the output when stage 2 can take it
	a_s1_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !(vld_s2 && rsp_stall)) |=> rsp_valid)
		else $error("stage 1 beat lost before output");

	// Input stalls only with the whole pipeline full and blocked
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (vld_s1 && vld_s2 && rsp_stall))
		else $error("input stalled with room in the pipeline");
`endif

endmodule
